FILE: rtl/core/cjd_pkg.sv
`default_nettype none
package cjd_pkg;

  localparam int unsigned SecsPerDay = 86400;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_GAP    = 2'd1,
    STAT_MONTH0 = 2'd2
  } cjd_status_t;

  typedef struct packed {
    logic signed [23:0] day_number;
    logic [16:0]        seconds_of_day;
    cjd_status_t        status;
  } cjd_result_t;

  // Days contributed by the month term, floor(30.6001 * (m + 1)), for m in 0..15.
  function automatic logic [8:0] month_days(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd30;
      4'd1:    r = 9'd61;
      4'd2:    r = 9'd91;
      4'd3:    r = 9'd122;
      4'd4:    r = 9'd153;
      4'd5:    r = 9'd183;
      4'd6:    r = 9'd214;
      4'd7:    r = 9'd244;
      4'd8:    r = 9'd275;
      4'd9:    r = 9'd306;
      4'd10:   r = 9'd336;
      4'd11:   r = 9'd367;
      4'd12:   r = 9'd397;
      4'd13:   r = 9'd428;
      4'd14:   r = 9'd459;
      4'd15:   r = 9'd489;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/calendar_to_julian_day.sv
// A result appears with done once the start transfer has passed the input registers and the result register.
// Throughput: one conversion per cycle; busy is never raised.
// Each result is strobed by done for exactly one cycle and the receiver cannot stall.
// Reset clears the pipeline valid flags; no result is lost except those in flight.
`default_nettype none
module calendar_to_julian_day import cjd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [14:0] year,
  input  logic [3:0]         month,
  input  logic [4:0]         day,
  input  logic [4:0]         hour,
  input  logic [5:0]         minute,
  input  logic [5:0]         second,
  input  logic signed [16:0] utc_offset,
  output logic               done,
  output logic signed [23:0] day_number,
  output logic [16:0]        seconds_of_day,
  output logic [1:0]         status
);

  logic               in_valid;
  logic signed [14:0] year_q;
  logic [3:0]         month_q;
  logic [4:0]         day_q;
  logic [4:0]         hour_q;
  logic [5:0]         minute_q;
  logic [5:0]         second_q;
  logic signed [16:0] offset_q;
  cjd_result_t        conv;
  cjd_result_t        res_q;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= start && !busy;
      done     <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      year_q   <= year;
      month_q  <= month;
      day_q    <= day;
      hour_q   <= hour;
      minute_q <= minute;
      second_q <= second;
      offset_q <= utc_offset;
    end
    if (in_valid) begin
      res_q <= conv;
    end
  end

  cjd_conv u_conv (
    .year       (year_q),
    .month      (month_q),
    .day        (day_q),
    .hour       (hour_q),
    .minute     (minute_q),
    .second     (second_q),
    .utc_offset (offset_q),
    .result     (conv)
  );

  assign day_number     = res_q.day_number;
  assign seconds_of_day = res_q.seconds_of_day;
  assign status         = res_q.status;

  a_start_enters: assert property (@(posedge clk) disable iff (rst)
    start |=> in_valid)
    else $error("accepted transfer did not enter the input stage");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done == $past(in_valid))
    else $error("done does not follow the input stage by one cycle");

  a_sec_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (seconds_of_day < 17'd86400))
    else $error("seconds_of_day out of range");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != STAT_OK)) |-> ((day_number == 24'sd0) && (seconds_of_day == 17'd0)))
    else $error("rejected date carries nonzero fields");

  a_month0: assert property (@(posedge clk) disable iff (rst)
    (in_valid && (month_q == 4'd0)) |=> (status == STAT_MONTH0))
    else $error("month zero not flagged");

endmodule
`default_nettype wire

FILE: rtl/core/cjd_conv.sv
`default_nettype none
module cjd_conv import cjd_pkg::*; (
  input  logic signed [14:0] year,
  input  logic [3:0]         month,
  input  logic [4:0]         day,
  input  logic [4:0]         hour,
  input  logic [5:0]         minute,
  input  logic [5:0]         second,
  input  logic signed [16:0] utc_offset,
  output cjd_result_t        result
);

  logic signed [15:0] y_adj;
  logic [3:0]         m_adj;
  logic               greg;
  logic               gap;
  logic [15:0]        y_off;
  logic [29:0]        y_prod;
  logic [10:0]        y_cent_pos;
  logic signed [10:0] y_cent;
  logic signed [11:0] b_corr;
  logic signed [16:0] y_shift;
  logic signed [27:0] y_mul;
  logic signed [27:0] y_days;
  logic [16:0]        hour_secs;
  logic [11:0]        min_secs;
  logic [16:0]        tod;
  logic signed [18:0] t_ut;
  logic signed [2:0]  carry;
  logic signed [18:0] sec_ut;
  logic signed [27:0] dn;

  always_comb begin
    // January and February count as months 13 and 14 of the previous year.
    if (month < 4'd3) begin
      y_adj = {year[14], year} - 16'sd1;
      m_adj = month + 4'd12;
    end else begin
      y_adj = {year[14], year};
      m_adj = month;
    end
  end

  // Lexicographic compare stands in for the packed yyyymmdd key.
  assign greg = (y_adj > 16'sd1582) ||
                ((y_adj == 16'sd1582) &&
                 ((m_adj > 4'd10) || ((m_adj == 4'd10) && (day >= 5'd15))));
  assign gap  = (y_adj == 16'sd1582) && (m_adj == 4'd10) &&
                (day inside {[5'd5:5'd14]});

  // Floor of year over 100: bias the year to a positive value that is a
  // multiple of 100, then divide by reciprocal multiplication.
  assign y_off      = $unsigned(y_adj) + 16'd16400;
  assign y_prod     = 30'(y_off) * 30'd5243;
  assign y_cent_pos = y_prod[29:19];
  assign y_cent     = $signed(y_cent_pos) - 11'sd164;
  assign b_corr     = 12'sd2 - {y_cent[10], y_cent} + {{3{y_cent[10]}}, y_cent[10:2]};

  assign y_shift = {y_adj[15], y_adj} + 17'sd4716;
  assign y_mul   = $signed({{11{y_shift[16]}}, y_shift}) * 28'sd1461;
  assign y_days  = y_mul >>> 2;

  assign hour_secs = 17'(hour) * 17'd3600;
  assign min_secs  = 12'(minute) * 12'd60;
  assign tod       = hour_secs + 17'(min_secs) + 17'(second);
  assign t_ut      = $signed({2'b00, tod}) - $signed({{2{utc_offset[16]}}, utc_offset});

  // The UT time of day lies well inside -1 to 3 days, so a few compares
  // give the floor of the day carry.
  always_comb begin
    if (t_ut < 19'sd0) begin
      carry  = -3'sd1;
      sec_ut = t_ut + 19'sd86400;
    end else if (t_ut < 19'sd86400) begin
      carry  = 3'sd0;
      sec_ut = t_ut;
    end else if (t_ut < 19'sd172800) begin
      carry  = 3'sd1;
      sec_ut = t_ut - 19'sd86400;
    end else begin
      carry  = 3'sd2;
      sec_ut = t_ut - 19'sd172800;
    end
  end

  assign dn = y_days
            + $signed({19'd0, month_days(m_adj)})
            + $signed({23'd0, day})
            + (greg ? $signed({{16{b_corr[11]}}, b_corr}) : 28'sd0)
            - 28'sd1524
            + $signed({{25{carry[2]}}, carry});

  always_comb begin
    if (month == 4'd0) begin
      result.day_number     = '0;
      result.seconds_of_day = '0;
      result.status         = STAT_MONTH0;
    end else if (gap) begin
      result.day_number     = '0;
      result.seconds_of_day = '0;
      result.status         = STAT_GAP;
    end else begin
      result.day_number     = dn[23:0];
      result.seconds_of_day = sec_ut[16:0];
      result.status         = STAT_OK;
    end
  end

endmodule
`default_nettype wire

FILE: dv/tb_calendar_to_julian_day.sv
`timescale 1ns / 100ps
module tb_calendar_to_julian_day import cjd_pkg::*; ();

  localparam int NumRandom   = 1530;
  localparam int QuietTail   = 150;
  localparam int CycleLimit  = 200000;
  localparam int ReportLimit = 10;

  typedef struct packed {
    logic signed [14:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic signed [16:0] utc_offset;
  } stamp_t;

  typedef struct packed {
    stamp_t      stamp;
    cjd_result_t jd;
  } jd_due_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [14:0] year = '0;
  logic [3:0]         month = '0;
  logic [4:0]         day = '0;
  logic [4:0]         hour = '0;
  logic [5:0]         minute = '0;
  logic [5:0]         second = '0;
  logic signed [16:0] utc_offset = '0;
  logic               done;
  logic signed [23:0] day_number;
  logic [16:0]        seconds_of_day;
  logic [1:0]         status;

  stamp_t  stamp_q[$];
  jd_due_t jd_due[$];
  int      idle_left = 0;
  int      idle_pct = 0;
  int      cycles = 0;
  int      mismatches = 0;
  int      n_checked = 0;
  int      n_gap = 0;
  int      n_month0 = 0;
  int      n_wrapped = 0;

  calendar_to_julian_day dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .year           (year),
    .month          (month),
    .day            (day),
    .hour           (hour),
    .minute         (minute),
    .second         (second),
    .utc_offset     (utc_offset),
    .done           (done),
    .day_number     (day_number),
    .seconds_of_day (seconds_of_day),
    .status         (status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  // Meeus conversion in exact integers; January and February belong to the prior year.
  function automatic cjd_result_t to_julian_day(stamp_t s);
    longint y, m, a, b, key, dn, t, carry, sec, dsec;
    cjd_result_t r;
    r = '0;
    dsec = longint'(SecsPerDay);
    y = $signed(s.year);
    m = s.month;
    b = 0;
    if (m == 0) begin
      r.status = STAT_MONTH0;
      return r;
    end
    if (m < 3) begin
      y = y - 1;
      m = m + 12;
    end
    key = y * 10000 + m * 100 + longint'(s.day);
    if (key >= 15821015) begin
      a = floor_quot(y, 100);
      b = 2 - a + floor_quot(a, 4);
    end else if (key > 15821004) begin
      r.status = STAT_GAP;
      return r;
    end
    dn = floor_quot(1461 * (y + 4716), 4) + floor_quot(306 * (m + 1), 10)
         + longint'(s.day) + b - 1524;
    t = longint'(s.hour) * 3600 + longint'(s.minute) * 60 + longint'(s.second)
        - longint'($signed(s.utc_offset));
    carry = floor_quot(t, dsec);
    sec = t - carry * dsec;
    dn = dn + carry;
    r.day_number = dn[23:0];
    r.seconds_of_day = sec[16:0];
    r.status = STAT_OK;
    return r;
  endfunction

  function automatic stamp_t mk(int y, int m, int d, int hh, int mi, int ss, int off);
    stamp_t s;
    s.year = 15'(y);
    s.month = 4'(m);
    s.day = 5'(d);
    s.hour = 5'(hh);
    s.minute = 6'(mi);
    s.second = 6'(ss);
    s.utc_offset = 17'(off);
    return s;
  endfunction

  function automatic stamp_t random_stamp();
    stamp_t s;
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      // Anything the field widths allow, including out of range values.
      s = stamp_t'({$urandom, $urandom});
    end else begin
      s = mk(int'($urandom_range(14711)) - 4712, $urandom_range(1, 12),
             $urandom_range(1, 31), $urandom_range(23), $urandom_range(59),
             $urandom_range(59), int'($urandom_range(100800)) - 50400);
      if (pick < 30) begin
        // Around the Gregorian reform, including the skipped days.
        s.year = $urandom_range(1) ? 15'sd1582 : 15'sd1583;
        s.month = $urandom_range(1) ? 4'd10 : 4'($urandom_range(1, 2));
        s.day = 5'($urandom_range(1, 20));
      end else if (pick < 45) begin
        // Times near midnight with offsets that borrow or carry a day.
        s.hour = $urandom_range(1) ? 5'd0 : 5'd23;
        s.utc_offset = 17'(int'($urandom_range(112)) * 900 - 50400);
      end
    end
    return s;
  endfunction

  // Driver: one transfer per cycle at most, with random idle bursts except near the end.
  always @(posedge clk) begin
    stamp_t nxt;
    logic   go;
    if (rst) begin
      start <= 1'b0;
      idle_left <= 0;
    end else begin
      if (start && !busy)
        jd_due.push_back({mk(year, month, day, hour, minute, second, utc_offset),
                          to_julian_day(mk(year, month, day, hour, minute, second,
                                           utc_offset))});
      go = start && busy;
      if (!go) begin
        if (idle_left != 0) begin
          idle_left <= idle_left - 1;
        end else if (stamp_q.size() != 0) begin
          if (stamp_q.size() % 100 == 0) idle_pct = $urandom_range(2) * 20;
          if (stamp_q.size() > QuietTail && $urandom_range(99) < idle_pct) begin
            idle_left <= $urandom_range(6);
          end else begin
            nxt = stamp_q.pop_front();
            year <= nxt.year;
            month <= nxt.month;
            day <= nxt.day;
            hour <= nxt.hour;
            minute <= nxt.minute;
            second <= nxt.second;
            utc_offset <= nxt.utc_offset;
            go = 1'b1;
          end
        end
      end
      start <= go;
    end
  end

  // Monitor: every strobed result must match the oldest outstanding conversion.
  always @(posedge clk) begin
    jd_due_t want;
    if (!rst && done) begin
      if (jd_due.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unexpected result: day_number=%0d seconds=%0d status=%0d",
                   day_number, seconds_of_day, status);
      end else begin
        want = jd_due.pop_front();
        n_checked++;
        if (want.jd.status == STAT_GAP) n_gap++;
        if (want.jd.status == STAT_MONTH0) n_month0++;
        if (want.jd.status == STAT_OK && (want.jd.day_number < 0)) n_wrapped++;
        if (day_number !== want.jd.day_number || seconds_of_day !== want.jd.seconds_of_day
            || status !== 2'(want.jd.status)) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("mismatch %0d-%0d-%0d %0d:%0d:%0d off %0d: exp %0d/%0d/%0d got %0d/%0d/%0d",
                     want.stamp.year, want.stamp.month, want.stamp.day, want.stamp.hour,
                     want.stamp.minute, want.stamp.second, want.stamp.utc_offset,
                     want.jd.day_number, want.jd.seconds_of_day, want.jd.status,
                     day_number, seconds_of_day, status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    stamp_q.push_back(mk(2000, 1, 1, 12, 0, 0, 0));
    stamp_q.push_back(mk(-4712, 1, 1, 12, 0, 0, 0));
    stamp_q.push_back(mk(-4712, 1, 1, 0, 0, 0, 1));
    stamp_q.push_back(mk(9999, 12, 31, 23, 59, 59, 0));
    stamp_q.push_back(mk(1999, 0, 15, 10, 20, 30, 3600));
    stamp_q.push_back(mk(1582, 10, 4, 12, 0, 0, 0));
    stamp_q.push_back(mk(1582, 10, 5, 12, 0, 0, 0));
    stamp_q.push_back(mk(1582, 10, 14, 12, 0, 0, 0));
    stamp_q.push_back(mk(1582, 10, 15, 12, 0, 0, 0));
    stamp_q.push_back(mk(1583, 2, 28, 6, 30, 0, -3600));
    stamp_q.push_back(mk(2024, 2, 29, 0, 0, 0, 50400));
    stamp_q.push_back(mk(2024, 3, 1, 23, 59, 59, -50400));
    stamp_q.push_back(mk(-16384, 1, 1, 0, 0, 0, 0));
    stamp_q.push_back(mk(16383, 12, 31, 23, 59, 59, 0));
    stamp_q.push_back(mk(1970, 1, 1, 0, 0, 0, -65536));
    stamp_q.push_back(mk(1970, 1, 1, 23, 59, 59, 65535));
    stamp_q.push_back(mk(1900, 6, 15, 31, 63, 63, -65536));
    stamp_q.push_back(mk(1900, 13, 10, 8, 0, 0, 0));
    stamp_q.push_back(mk(1900, 14, 10, 8, 0, 0, 0));
    stamp_q.push_back(mk(1900, 15, 31, 8, 0, 0, 0));
    stamp_q.push_back(mk(2100, 3, 0, 0, 0, 0, 0));
    stamp_q.push_back(mk(1600, 2, 31, 12, 0, 0, 0));
    stamp_q.push_back(mk(-1, 0, 0, 0, 0, 0, -1));
    for (int i = 0; i < NumRandom; i++) stamp_q.push_back(random_stamp());

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (stamp_q.size() != 0 || start || jd_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("checked %0d conversions: %0d in the reform gap, %0d with month zero,",
             n_checked, n_gap, n_month0);
    $display("%0d with a wrapped day number; %0d mismatches", n_wrapped, mismatches);
    if (mismatches == 0 && jd_due.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: calendar_to_julian_day.f
rtl/core/cjd_pkg.sv
rtl/core/cjd_conv.sv
rtl/core/calendar_to_julian_day.sv
dv/tb_calendar_to_julian_day.sv
